/* src/decimal_number_extract_sort_assert.svh */
// assertion macros for the decimal number extract and sort block
`ifndef DECIMAL_NUMBER_EXTRACT_SORT_ASSERT_SVH
`define DECIMAL_NUMBER_EXTRACT_SORT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DNES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define DNES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/dnes_pkg.sv */
`default_nettype none
package dnes_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 7;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [VAL_W-1:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] char_byte;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
    logic             overflowed;
  } out_t;

  // broadcast from the control to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* src/dnes_cell.sv */
`default_nettype none
module dnes_cell #(
  parameter int IDX = 0
) (
  input  wire                          clk,
  input  dnes_pkg::cell_cmd_t          cmd,
  input  wire [dnes_pkg::VAL_W-1:0]    left_val,
  input  wire                          left_gt,
  input  wire [dnes_pkg::VAL_W-1:0]    right_val,
  output logic [dnes_pkg::VAL_W-1:0]   val,
  output logic                         gt
);
  import dnes_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic             occ;

  assign occ = (IDX_C < cmd.count);
  assign gt  = occ && (val_r > cmd.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.shift) begin
      val_nxt = right_val;
    end else if (cmd.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt || (IDX_C == cmd.count)) begin
        val_nxt = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

/* src/decimal_number_extract_sort.sv */
// decimal number extract and sort
// input channel: a transaction is taken at a rising edge with start high and
//   busy low. in_data.action 0 carries a text byte, 1 marks end of text.
// text bytes are taken one per cycle; each maximal digit run becomes an
//   unsigned value (saturating at 2^32-1) that is inserted into a row of
//   MAX_NUMBERS sorted cells in the cycle the run closes.
// end of text: busy goes high until the stored values have been emitted;
//   the results leave cell 0 one per cycle while the row shifts left.
// result channel: out_valid is high for exactly one cycle per result, in the
//   cycle after the shift that produced it; out_data.last marks the final one
//   and out_data.overflowed reports numbers dropped on a full row.
// an end of text with nothing stored gives no result.
// the receiver cannot stall; results are never held back.
// reset clears the parser, the count and the drop flag; cell contents are
//   only read below the count and need no clearing.
`default_nettype none
module decimal_number_extract_sort #(
  parameter int MAX_NUMBERS = 64
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  output logic            busy,
  input  dnes_pkg::in_t   in_data,
  output logic            out_valid,
  output dnes_pkg::out_t  out_data
);
  import dnes_pkg::*;

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_NUMBERS);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic             in_num_r, in_num_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic             accept;
  logic             is_digit;
  logic [3:0]       digit;
  logic [VAL_W-1:0] acc_base;
  logic [VAL_W+3:0] prod;
  logic             close_run;
  logic             emit;
  cell_cmd_t        cmd;

  logic [VAL_W-1:0] cell_val [MAX_NUMBERS];
  logic             cell_gt  [MAX_NUMBERS];

  assign busy     = (state_r == ST_EMIT);
  assign accept   = start && !busy;
  assign is_digit = (in_data.char_byte >= CH_ZERO) && (in_data.char_byte <= CH_NINE);
  assign digit    = 4'(in_data.char_byte - CH_ZERO);
  assign acc_base = in_num_r ? acc_r : '0;
  assign prod     = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                  + {{(VAL_W){1'b0}}, digit};
  assign close_run = accept && in_num_r &&
                     ((in_data.action == ACT_END) || !is_digit);
  assign emit     = (state_r == ST_EMIT) && (count_r != '0);

  assign cmd.ins   = close_run && (count_r < MAX_C);
  assign cmd.shift = emit;
  assign cmd.count = count_r;
  assign cmd.value = acc_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_NUMBERS; gi++) begin : g_cell
      logic [VAL_W-1:0] lv;
      logic             lg;
      logic [VAL_W-1:0] rv;
      if (gi == 0) begin : g_first
        assign lv = '0;
        assign lg = 1'b0;
      end else begin : g_mid
        assign lv = cell_val[gi-1];
        assign lg = cell_gt[gi-1];
      end
      if (gi == MAX_NUMBERS - 1) begin : g_last
        assign rv = cell_val[gi];
      end else begin : g_inner
        assign rv = cell_val[gi+1];
      end
      dnes_cell #(
        .IDX (gi)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .left_val  (lv),
        .left_gt   (lg),
        .right_val (rv),
        .val       (cell_val[gi]),
        .gt        (cell_gt[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    in_num_nxt    = in_num_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (close_run) begin
      if (count_r < MAX_C) begin
        count_nxt = count_r + 1'b1;
      end else begin
        drop_nxt = 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_END) begin
            acc_nxt    = '0;
            in_num_nxt = 1'b0;
            state_nxt  = ST_EMIT;
          end else if (is_digit) begin
            acc_nxt    = (prod[VAL_W+3:VAL_W] != '0) ? SAT32 : prod[VAL_W-1:0];
            in_num_nxt = 1'b1;
          end else begin
            acc_nxt    = '0;
            in_num_nxt = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_nxt      = 1'b1;
          out_nxt.value      = cell_val[0];
          out_nxt.last       = (count_r == CNT_W'(1));
          out_nxt.overflowed = drop_r;
          count_nxt          = count_r - 1'b1;
        end
        if (count_r <= CNT_W'(1)) begin
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      in_num_r    <= 1'b0;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      in_num_r    <= in_num_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* src/dnes_chk.sv */
`default_nettype none
`include "decimal_number_extract_sort_assert.svh"
module dnes_chk (
  input wire            clk,
  input wire            rst_n,
  input wire            start,
  input wire            busy,
  input dnes_pkg::in_t  in_data,
  input wire            out_valid,
  input dnes_pkg::out_t out_data
);
  import dnes_pkg::*;

  // a result that is not the final one comes while the block is busy
  `DNES_ASSERT_SAME(a_mid_busy, clk, rst_n, out_valid && !out_data.last, busy)
  // a text byte never causes a result
  `DNES_ASSERT_NEXT(a_text_quiet, clk, rst_n, start && !busy && (in_data.action == ACT_CHAR), !out_valid)
  // results of one run are back to back and end after the final one
  `DNES_ASSERT_NEXT(a_run_gapless, clk, rst_n, out_valid && !out_data.last, out_valid)
  `DNES_ASSERT_NEXT(a_run_ends, clk, rst_n, out_valid && out_data.last, !out_valid)
  // ascending order within a run
  `DNES_ASSERT_NEXT(a_ascending, clk, rst_n, out_valid && !out_data.last, out_data.value >= $past(out_data.value))

endmodule

bind decimal_number_extract_sort dnes_chk u_dnes_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
